// ===== sv/mf_pkg.sv =====
// Shared types, constants and compare helpers for the 3x3 median filter.
// No dependencies; every other file of the block imports this package.
package mf_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned FW_W       = 11;   // frame_width register
  localparam int unsigned FH_W       = 13;   // frame_height register, row counters
  localparam int unsigned CFG_W      = 13;   // widest register
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned MIN_DIM    = 3;

  typedef logic [PIX_W-1:0] pix_t;

  // three consecutive pixels; index 0 is the newest (or the lowest once sorted)
  typedef logic [2:0][PIX_W-1:0] pix3_t;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  // per-beat control travelling down the pipe
  typedef struct packed {
    logic vld;     // beat present in this stage
    logic res;     // beat yields a result
    logic border;  // result is the center pixel, not the median
    logic fend;    // result is the last pixel of the frame
  } tag_t;

  function automatic pix_t min2(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(input pix_t a, input pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
    return min2(min2(a, b), c);
  endfunction

  function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
    return max2(max2(a, b), c);
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  // three compare-exchanges, result ascending from index 0
  function automatic pix3_t sort3(input pix3_t v);
    pix3_t s;
    s = v;
    if (s[0] > s[1]) begin
      s[0] = v[1];
      s[1] = v[0];
    end
    if (s[1] > s[2]) begin
      s[2] = s[1];
      s[1] = v[2];
    end
    if (s[0] > s[1]) begin
      s = {s[2], s[0], s[1]};
    end
    return s;
  endfunction

endpackage

// ===== sv/median_filter_3x3.sv =====
// Top level of the 3x3 median filter for 8-bit grey raster frames.
// Depends on mf_pkg, mf_ctrl, mf_line_mem and mf_median.
//
// Usage:
//   Slave stream: one pixel per beat in raster order; tuser marks the first
//   pixel of a frame. Master stream: one filtered pixel per result; tlast
//   marks the last pixel of the frame. Interior pixels get the median of
//   their 3x3 neighborhood, border rows and columns pass through.
//   The result for a pixel is produced by the beat one row plus one pixel
//   later, so frame_width+1 extra beats (any data) after a frame drain it.
//   Config port: index 0 frame_width (3..MAX_WIDTH), index 1 frame_height
//   (3..4096); out-of-range values saturate, frame_width after truncation to 11 bits. Write only while idle.
//   Throughput: one beat per clock while no result is held at the master side.
//   Each accepted beat passes the five-register pipe (address, line-store
//   read, row sort, column reduce, output) on its way to the master side.
//   The line store is one write and two reads per beat, each word holding
//   three consecutive pixels.
//   Reset: geometry returns to 640x480 and counters behave as if a frame
//   had just started; the line store is not cleared.
//   Stall: while the master holds a result unaccepted, the whole pipe
//   freezes and s_axis_tready drops; nothing is lost or repeated.
module median_filter_3x3 #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [7:0]               s_axis_tdata,   // [7:0] pixel_in
  input  logic                     s_axis_tuser,   // [0] frame_start
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [7:0]               m_axis_tdata,   // [7:0] pixel_out
  output logic                     m_axis_tlast,   // frame_end
  input  logic                     cfg_we_i,
  input  logic [0:0]               cfg_idx_i,
  input  logic [mf_pkg::CFG_W-1:0] cfg_data_i
);
  import mf_pkg::*;

  // line store spans two rows plus the group lag
  localparam int unsigned ADDR_W = $clog2(2 * MAX_WIDTH + 3);

  logic              en;
  tag_t              s1_tag, s2_tag;
  pix3_t             s1_wdata, s2_bot, s2_mid, s2_top;
  logic [ADDR_W-1:0] s1_waddr, s1_raddr_mid, s1_raddr_top;

  // single pipe enable: advance unless a result is held at the output
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  mf_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .ADDR_W    (ADDR_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (s_axis_tvalid),
    .pixel_i     (s_axis_tdata),
    .fstart_i    (s_axis_tuser),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .tag_o       (s1_tag),
    .wdata_o     (s1_wdata),
    .waddr_o     (s1_waddr),
    .raddr_mid_o (s1_raddr_mid),
    .raddr_top_o (s1_raddr_top)
  );

  mf_line_mem #(
    .ADDR_W (ADDR_W)
  ) u_line_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .tag_i       (s1_tag),
    .wdata_i     (s1_wdata),
    .waddr_i     (s1_waddr),
    .raddr_mid_i (s1_raddr_mid),
    .raddr_top_i (s1_raddr_top),
    .tag_o       (s2_tag),
    .bot_o       (s2_bot),
    .mid_o       (s2_mid),
    .top_o       (s2_top)
  );

  mf_median u_median (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .tag_i   (s2_tag),
    .bot_i   (s2_bot),
    .mid_i   (s2_mid),
    .top_i   (s2_top),
    .valid_o (m_axis_tvalid),
    .pixel_o (m_axis_tdata),
    .last_o  (m_axis_tlast)
  );

  // a frame start always begins the lead-in: no result from that beat
  a_fstart_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser) |=> !s1_tag.res)
    else $error("frame start beat produced a result");

  // the first stage holds still while the pipe is frozen
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(s1_tag))
    else $error("stage 1 moved during a stall");

  // a new result only appears after the pipe advanced
  a_result_after_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(en))
    else $error("result appeared without pipe advance");

endmodule

// ===== sv/mf_ctrl.sv =====
// Frame geometry registers, input/output position counters and line
// address generation (first pipe stage). Depends on mf_pkg.
module mf_ctrl #(
  parameter int unsigned MAX_WIDTH = 1024,
  parameter int unsigned ADDR_W    = 12
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  mf_pkg::pix_t             pixel_i,
  input  logic                     fstart_i,
  input  logic                     cfg_we_i,
  input  logic [0:0]               cfg_idx_i,
  input  logic [mf_pkg::CFG_W-1:0] cfg_data_i,
  output mf_pkg::tag_t             tag_o,
  output mf_pkg::pix3_t            wdata_o,
  output logic [ADDR_W-1:0]        waddr_o,
  output logic [ADDR_W-1:0]        raddr_mid_o,
  output logic [ADDR_W-1:0]        raddr_top_o
);
  import mf_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned LW = CW + 1;
  localparam int unsigned EW = (CW > FW_W) ? CW : FW_W;

  logic [FW_W-1:0]   fwidth_q;
  logic [FH_W-1:0]   fheight_q;
  logic [CW-1:0]     col_q, col_d, ocol_q, ocol_d;
  logic [FH_W-1:0]   row_q, row_d, orow_q, orow_d;
  logic [LW-1:0]     lead_q, lead_d;
  logic [ADDR_W-1:0] pos_q, pos_d;
  pix_t              hist1_q, hist2_q, val;

  logic [CW-1:0]   w;
  logic [FH_W-1:0] h;
  logic [EW-1:0]   fw_ext;
  logic [CW-1:0]   col_c, ocol_c;
  logic [FH_W-1:0] row_c, orow_c;
  logic [LW-1:0]   lead_c, col_inc, ocol_inc, w_ext;
  logic [FH_W-1:0] orow_inc;
  logic            accept, res, border, fend;

  assign accept = valid_i & en_i;

  // effective geometry, saturated to the supported range
  assign fw_ext = EW'(fwidth_q);
  always_comb begin
    if (fw_ext < EW'(MIN_DIM)) begin
      w = CW'(MIN_DIM);
    end else if (fw_ext > EW'(MAX_WIDTH)) begin
      w = CW'(MAX_WIDTH);
    end else begin
      w = CW'(fw_ext);
    end
    if (fheight_q < FH_W'(MIN_DIM)) begin
      h = FH_W'(MIN_DIM);
    end else if (fheight_q > FH_W'(MAX_HEIGHT)) begin
      h = FH_W'(MAX_HEIGHT);
    end else begin
      h = fheight_q;
    end
  end

  always_comb begin
    col_c  = fstart_i ? '0 : col_q;
    row_c  = fstart_i ? '0 : row_q;
    ocol_c = fstart_i ? '0 : ocol_q;
    orow_c = fstart_i ? '0 : orow_q;
    lead_c = fstart_i ? '0 : lead_q;

    w_ext    = LW'(w);
    col_inc  = LW'(col_c) + LW'(1);
    ocol_inc = LW'(ocol_c) + LW'(1);
    orow_inc = orow_c + FH_W'(1);

    pos_d  = pos_q + ADDR_W'(1);
    col_d  = col_c;
    row_d  = row_c;
    ocol_d = ocol_c;
    orow_d = orow_c;
    lead_d = lead_c;

    // past the last row the line store takes zeros
    val = '0;
    if (row_c < h) begin
      val = pixel_i;
      if (col_inc >= w_ext) begin
        col_d = '0;
        row_d = row_c + FH_W'(1);
      end else begin
        col_d = CW'(col_inc);
      end
    end

    res = 1'b0;
    if (lead_c < w_ext + LW'(1)) begin
      lead_d = lead_c + LW'(1);
    end else if (orow_c < h) begin
      res = 1'b1;
      if (ocol_inc >= w_ext) begin
        ocol_d = '0;
        orow_d = orow_inc;
      end else begin
        ocol_d = CW'(ocol_inc);
      end
    end

    border = !((orow_c != '0) && (orow_inc < h) && (ocol_c != '0) && (ocol_inc < w_ext));
    fend   = (orow_inc == h) && (ocol_inc >= w_ext);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwidth_q  <= FW_W'(640);
      fheight_q <= FH_W'(480);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_FRAME_WIDTH:  fwidth_q  <= cfg_data_i[FW_W-1:0];
        REG_FRAME_HEIGHT: fheight_q <= cfg_data_i[FH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      ocol_q  <= '0;
      orow_q  <= '0;
      lead_q  <= '0;
      pos_q   <= '0;
      hist1_q <= '0;
      hist2_q <= '0;
      tag_o   <= '0;
    end else if (en_i) begin
      tag_o <= '{vld: accept, res: res, border: border, fend: fend};
      if (accept) begin
        col_q   <= col_d;
        row_q   <= row_d;
        ocol_q  <= ocol_d;
        orow_q  <= orow_d;
        lead_q  <= lead_d;
        pos_q   <= pos_d;
        hist1_q <= val;
        hist2_q <= hist1_q;
      end
    end
  end

  // stage-1 payload: three newest pixels and the line addresses
  always_ff @(posedge clk_i) begin
    if (accept) begin
      wdata_o     <= {hist2_q, hist1_q, val};
      waddr_o     <= pos_d;
      raddr_mid_o <= pos_d - ADDR_W'(w);
      raddr_top_o <= pos_d - ADDR_W'({w, 1'b0});
    end
  end

endmodule

// ===== sv/mf_line_mem.sv =====
// Line store: every beat writes its three-pixel group, two reads fetch the
// groups one and two rows back (second pipe stage). Depends on mf_pkg.
module mf_line_mem #(
  parameter int unsigned ADDR_W = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  mf_pkg::tag_t        tag_i,
  input  mf_pkg::pix3_t       wdata_i,
  input  logic [ADDR_W-1:0]   waddr_i,
  input  logic [ADDR_W-1:0]   raddr_mid_i,
  input  logic [ADDR_W-1:0]   raddr_top_i,
  output mf_pkg::tag_t        tag_o,
  output mf_pkg::pix3_t       bot_o,
  output mf_pkg::pix3_t       mid_o,
  output mf_pkg::pix3_t       top_o
);
  import mf_pkg::*;

  pix3_t line_mem [2**ADDR_W];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (tag_i.vld) begin
        line_mem[waddr_i] <= wdata_i;
      end
      mid_o <= line_mem[raddr_mid_i];
      top_o <= line_mem[raddr_top_i];
      bot_o <= wdata_i;
    end
  end

  // only beats that yield a result stay valid past this stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_o <= '0;
    end else if (en_i) begin
      tag_o <= '{vld: tag_i.vld & tag_i.res, res: tag_i.res,
                 border: tag_i.border, fend: tag_i.fend};
    end
  end

endmodule

// ===== sv/mf_median.sv =====
// Median-of-nine network over three stages: row sorts, column reduce,
// final med3 with border bypass into the output register. Depends on mf_pkg.
module mf_median (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  mf_pkg::tag_t  tag_i,
  input  mf_pkg::pix3_t bot_i,
  input  mf_pkg::pix3_t mid_i,
  input  mf_pkg::pix3_t top_i,
  output logic          valid_o,
  output mf_pkg::pix_t  pixel_o,
  output logic          last_o
);
  import mf_pkg::*;

  tag_t  tag3_q, tag4_q;
  pix3_t srt_bot_q, srt_mid_q, srt_top_q;
  pix_t  ctr3_q, ctr4_q;
  pix_t  lo_max_q, mid_med_q, hi_min_q;
  pix_t  med;

  assign med = med3(lo_max_q, mid_med_q, hi_min_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag3_q  <= '0;
      tag4_q  <= '0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      tag3_q  <= tag_i;
      tag4_q  <= tag3_q;
      valid_o <= tag4_q.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      srt_bot_q <= sort3(bot_i);
      srt_mid_q <= sort3(mid_i);
      srt_top_q <= sort3(top_i);
      ctr3_q    <= mid_i[1];

      lo_max_q  <= max3(srt_bot_q[0], srt_mid_q[0], srt_top_q[0]);
      mid_med_q <= med3(srt_bot_q[1], srt_mid_q[1], srt_top_q[1]);
      hi_min_q  <= min3(srt_bot_q[2], srt_mid_q[2], srt_top_q[2]);
      ctr4_q    <= ctr3_q;

      pixel_o   <= tag4_q.border ? ctr4_q : med;
      last_o    <= tag4_q.fend;
    end
  end

endmodule

// ===== tb/sv/median_filter_3x3_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for median_filter_3x3: follows config writes and accepted pixel beats,
// predicts every filtered pixel and compares it with the beats on the master side.
// Depends on mf_pkg for widths, limits and register codes.
module median_filter_3x3_checker #(
  parameter int unsigned MAX_W = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  input  logic                     s_axis_tready,
  input  logic [7:0]               s_axis_tdata,   // [7:0] pixel_in
  input  logic                     s_axis_tuser,   // [0] frame_start
  input  logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  input  logic [7:0]               m_axis_tdata,   // [7:0] pixel_out
  input  logic                     m_axis_tlast,   // frame_end
  input  logic                     cfg_we_i,
  input  logic [0:0]               cfg_idx_i,
  input  logic [mf_pkg::CFG_W-1:0] cfg_data_i,
  output int                       pending_o,
  output int                       fail_cnt_o
);
  import mf_pkg::*;

  localparam int unsigned RING_D = 2 * MAX_W + 4;

  typedef struct packed {
    pix_t px;
    logic fend;
  } filt_px_t;

  filt_px_t    filtered_q[$];
  pix_t        line_ring [RING_D];
  logic [FW_W-1:0] fw_q;
  logic [FH_W-1:0] fh_q;
  int unsigned wr_pos;
  int unsigned in_col, in_row, out_col, out_row, lead_cnt;
  int          n_fail;

  // pixel d beats back in the delay line
  function automatic pix_t pixel_back(input int unsigned d);
    return line_ring[(wr_pos + RING_D - d) % RING_D];
  endfunction

  function automatic pix_t median9(input pix_t v [9]);
    pix_t s [9];
    pix_t t;
    int   i, j;
    s = v;
    for (i = 1; i < 9; i++) begin
      t = s[i];
      j = i;
      while (j > 0 && s[j-1] > t) begin
        s[j] = s[j-1];
        j--;
      end
      s[j] = t;
    end
    return s[4];
  endfunction

  // one accepted input beat: update position state, queue the filtered pixel it releases
  task automatic filter_step(input pix_t px, input logic fs);
    int unsigned w, h, k;
    pix_t        win [9];
    filt_px_t    r;
    w = (fw_q < MIN_DIM) ? MIN_DIM : ((fw_q > MAX_W) ? MAX_W : fw_q);
    h = (fh_q < MIN_DIM) ? MIN_DIM : ((fh_q > MAX_HEIGHT) ? MAX_HEIGHT : fh_q);
    if (fs) begin
      in_col   = 0;
      in_row   = 0;
      out_col  = 0;
      out_row  = 0;
      lead_cnt = 0;
    end
    wr_pos = (wr_pos + 1) % RING_D;
    if (in_row < h) begin
      line_ring[wr_pos] = px;
      if (in_col + 1 >= w) begin
        in_col = 0;
        in_row++;
      end else begin
        in_col++;
      end
    end else begin
      line_ring[wr_pos] = '0;   // past the last row: flush beat
    end
    if (lead_cnt < w + 1) begin
      lead_cnt++;
      return;
    end
    if (out_row >= h) return;
    if (out_row >= 1 && out_row + 1 < h && out_col >= 1 && out_col + 1 < w) begin
      for (k = 0; k < 9; k++) win[k] = pixel_back(2 * w + 2 - (k / 3) * w - (k % 3));
      r.px = median9(win);
    end else begin
      r.px = pixel_back(w + 1);
    end
    r.fend = (out_row + 1 == h) && (out_col + 1 >= w);
    if (out_col + 1 >= w) begin
      out_col = 0;
      out_row++;
    end else begin
      out_col++;
    end
    filtered_q.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    filt_px_t got, want;
    if (!rst_ni) begin
      fw_q     = 11'd640;
      fh_q     = 13'd480;
      wr_pos   = 0;
      in_col   = 0;
      in_row   = 0;
      out_col  = 0;
      out_row  = 0;
      lead_cnt = 0;
      n_fail   = 0;
      filtered_q.delete();
      pending_o  <= 0;
      fail_cnt_o <= 0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          REG_FRAME_WIDTH:  fw_q = cfg_data_i[FW_W-1:0];
          REG_FRAME_HEIGHT: fh_q = cfg_data_i[FH_W-1:0];
          default: ;
        endcase
      end
      // output side first: a result can never stem from the beat taken at this edge
      if (m_axis_tvalid && m_axis_tready) begin
        got.px   = m_axis_tdata;
        got.fend = m_axis_tlast;
        if (filtered_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("unexpected result beat: pixel %0d last %0b", got.px, got.fend);
        end else begin
          want = filtered_q.pop_front();
          if (got.px !== want.px || got.fend !== want.fend) begin
            n_fail++;
            if (n_fail <= 10)
              $display("result mismatch: expected pixel %0d last %0b, got pixel %0d last %0b",
                       want.px, want.fend, got.px, got.fend);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) filter_step(s_axis_tdata, s_axis_tuser);
      pending_o  <= filtered_q.size();
      fail_cnt_o <= n_fail;
    end
  end

endmodule

// ===== tb/sv/median_filter_3x3_tb.sv =====
`timescale 1ns / 1ps
// Top of the median_filter_3x3 testbench: clock, reset, pixel and config stimulus.
// Needs mf_pkg, the filter RTL and median_filter_3x3_checker.
module median_filter_3x3_tb;
  import mf_pkg::*;

  localparam int unsigned MAX_W       = 1024;
  localparam int unsigned SETTLE      = 12;        // pipe is 5 deep, leave margin
  localparam int unsigned RAND_BEATS  = 960;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  // pixel content of a frame
  typedef enum int {
    PX_RANDOM,    // full range
    PX_EXTREME,   // rails and next-to-rails only
    PX_NOISY,     // small noise around a level, medians stay close
    PX_SALT       // flat level with impulse noise, what the filter is for
  } px_style_e;

  // receiver behavior per stretch
  typedef enum int {
    RX_OPEN,
    RX_BUSY,
    RX_CHOKE
  } rx_mode_e;

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata;   // [7:0] pixel_in
  logic             s_axis_tuser;   // [0] frame_start
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [7:0]       m_axis_tdata;   // [7:0] pixel_out
  logic             m_axis_tlast;   // frame_end
  logic             cfg_we_i;
  logic [0:0]       cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  int          pending;      // filtered pixels still owed by the block
  int          fail_cnt;
  int          burst_left;   // sender beats left before the next possible gap
  int          pix_level;    // base grey level of the current frame
  int unsigned cur_w, cur_h; // geometry as the block applies it (saturated)
  int unsigned cycle_cnt;
  rx_mode_e    rx_mode;
  int          rx_left;

  median_filter_3x3 #(
    .MAX_WIDTH(MAX_W)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  median_filter_3x3_checker #(
    .MAX_W(MAX_W)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .pending_o     (pending),
    .fail_cnt_o    (fail_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs or owes results forever
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: stretches of always-ready, mostly-ready and mostly-stalled.
  // A stall freezes the whole pipe, so it also backs up onto s_axis_tready.
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 2));
      rx_left = $urandom_range(16, 256);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:  m_axis_tready <= 1'b1;
      RX_BUSY:  m_axis_tready <= ($urandom_range(0, 3) != 0);
      default:  m_axis_tready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  function automatic pix_t gen_pixel(input px_style_e style);
    int v;
    case (style)
      PX_EXTREME: begin
        case ($urandom_range(0, 3))
          0:       return 8'h00;
          1:       return 8'hFF;
          2:       return 8'h01;
          default: return 8'hFE;
        endcase
      end
      PX_NOISY: begin
        v = pix_level + int'($urandom_range(0, 16)) - 8;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return pix_t'(v);
      end
      PX_SALT: begin
        if ($urandom_range(0, 5) == 0) return ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
        return pix_t'(pix_level);
      end
      default: return pix_t'($urandom_range(0, 255));
    endcase
  endfunction

  // One beat on the slave side. The sender runs in bursts; a random gap may
  // open before a new burst. Valid stays high across back-to-back beats.
  task automatic push_pixel(input pix_t px, input logic fs);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                               : $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    s_axis_tuser  <= fs;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // n pixels in raster order; the first one carries frame_start if asked
  task automatic stream_pixels(input int unsigned n, input px_style_e style, input logic start);
    int unsigned i;
    for (i = 0; i < n; i++) push_pixel(gen_pixel(style), start && (i == 0));
  endtask

  // drain beats after a frame; their data is don't-care, so make it random
  task automatic stream_flush(input int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) push_pixel(pix_t'($urandom_range(0, 255)), 1'b0);
  endtask

  // block counts as idle once nothing is owed and the pipe had time to empty
  task automatic drain_wait();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] val);
    int unsigned v;
    drain_wait();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    // keep the saturated geometry for frame lengths
    if (idx == REG_FRAME_WIDTH) begin
      v = 32'(val[FW_W-1:0]);
      cur_w = (v < MIN_DIM) ? MIN_DIM : ((v > MAX_W) ? MAX_W : v);
    end else begin
      v = 32'(val[FH_W-1:0]);
      cur_h = (v < MIN_DIM) ? MIN_DIM : ((v > MAX_HEIGHT) ? MAX_HEIGHT : v);
    end
  endtask

  initial begin
    int unsigned rand_beats, n, k, r, w_raw, h_raw, kind;
    px_style_e   style;
    logic        clean;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    m_axis_tready <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= '0;
    cfg_data_i    <= '0;
    cur_w     = 640;
    cur_h     = 480;
    pix_level = 128;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed part ---
    // Reset geometry (640x480) without frame_start: lead-in of one row plus one
    // pixel, then pass-through results of the top border row.
    stream_pixels(660, PX_RANDOM, 1'b0);

    // zero registers saturate to the smallest 3x3 frame; rails as data
    write_reg(REG_FRAME_WIDTH, '0);
    write_reg(REG_FRAME_HEIGHT, '0);
    stream_pixels(9, PX_EXTREME, 1'b1);
    stream_flush(4);
    // surplus beats after the last result of a frame: nothing comes out
    stream_pixels(3, PX_RANDOM, 1'b0);

    // frame_start in the middle of a frame drops what the old frame owed
    stream_pixels(5, PX_RANDOM, 1'b1);
    stream_pixels(9, PX_SALT, 1'b1);
    stream_flush(4);

    // 5x4 with impulse noise: real medians on the inner 3x2
    write_reg(REG_FRAME_WIDTH, 13'd5);
    write_reg(REG_FRAME_HEIGHT, 13'd4);
    pix_level = 77;
    stream_pixels(20, PX_SALT, 1'b1);
    stream_flush(6);

    // height shrinks mid-frame (2 saturates to 3)
    write_reg(REG_FRAME_WIDTH, 13'd4);
    write_reg(REG_FRAME_HEIGHT, 13'd6);
    pix_level = 200;
    stream_pixels(10, PX_NOISY, 1'b1);
    write_reg(REG_FRAME_HEIGHT, 13'd2);
    stream_pixels(6, PX_RANDOM, 1'b0);
    stream_flush(5);
    stream_pixels(2, PX_RANDOM, 1'b0);

    // width shrinks mid-frame: column counters wrap at the new edge
    write_reg(REG_FRAME_WIDTH, 13'd8);
    write_reg(REG_FRAME_HEIGHT, 13'd5);
    pix_level = 30;
    stream_pixels(20, PX_NOISY, 1'b1);
    write_reg(REG_FRAME_WIDTH, 13'd5);
    stream_pixels(15, PX_NOISY, 1'b0);
    stream_flush(6);

    // widest: all-ones width register saturates to MAX_W; a short partial
    // frame stays inside the lead-in, so nothing may come out
    write_reg(REG_FRAME_WIDTH, 13'd2047);
    write_reg(REG_FRAME_HEIGHT, 13'd3);
    pix_level = 140;
    stream_pixels(40, PX_NOISY, 1'b1);

    // tallest: all-ones height register saturates to 4096 rows, kept narrow;
    // the first rows only, the next frame_start cuts it off
    write_reg(REG_FRAME_WIDTH, 13'd3);
    write_reg(REG_FRAME_HEIGHT, 13'd8191);
    pix_level = 90;
    stream_pixels(60, PX_SALT, 1'b1);

    // --- random part ---
    // Mostly complete frames with random content; some cut short by a new
    // frame_start, some with a short flush, some without frame_start at all.
    // Geometry only changes after a fully drained frame.
    clean      = 1'b1;
    rand_beats = 0;
    while (rand_beats < RAND_BEATS) begin
      if (rand_beats == 0 || (clean && $urandom_range(0, 1) == 1)) begin
        r = $urandom_range(0, 19);
        w_raw = (r < 14) ? $urandom_range(3, 10)
              : (r < 18) ? $urandom_range(11, 40) : $urandom_range(41, 130);
        h_raw = $urandom_range(3, 8);
        if ($urandom_range(0, 9) == 0) w_raw = $urandom_range(0, 2);
        if ($urandom_range(0, 9) == 0) h_raw = $urandom_range(0, 2);
        write_reg(REG_FRAME_WIDTH, CFG_W'(w_raw));
        write_reg(REG_FRAME_HEIGHT, CFG_W'(h_raw));
      end
      kind      = $urandom_range(0, 9);
      style     = px_style_e'($urandom_range(0, 3));
      pix_level = $urandom_range(0, 255);
      n         = cur_w * cur_h;
      if (kind == 9 && clean) begin
        // no frame_start after a finished frame: the block drops these beats
        stream_pixels($urandom_range(1, cur_w), PX_RANDOM, 1'b0);
      end else if (kind == 8) begin
        n = $urandom_range(1, n - 1);
        stream_pixels(n, style, 1'b1);
        rand_beats += n;
        clean = 1'b0;
      end else if (kind == 7) begin
        k = $urandom_range(0, cur_w);
        stream_pixels(n, style, 1'b1);
        stream_flush(k);
        rand_beats += n + k;
        clean = 1'b0;
      end else begin
        stream_pixels(n, style, 1'b1);
        stream_flush(cur_w + 1);
        rand_beats += n + cur_w + 1;
        clean = 1'b1;
      end
    end

    drain_wait();
    if (fail_cnt == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/mf_pkg.sv
sv/mf_ctrl.sv
sv/mf_line_mem.sv
sv/mf_median.sv
sv/median_filter_3x3.sv
tb/sv/median_filter_3x3_checker.sv
tb/sv/median_filter_3x3_tb.sv
